FILE: rtl/core/bbc_pkg.sv
// Shared types for the biconnected block counter: item structs, the command
// and status groups between controller and datapath, and default sizes.
// No dependencies.
`default_nettype none

package bbc_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    typedef struct packed {
        logic       func;
        logic [6:0] first_vertex;
        logic [6:0] second_vertex;
    } in_item_t;

    typedef struct packed {
        logic [6:0] block_vertices;
        logic [8:0] block_edges;
        logic       last_block;
        logic       input_dropped;
    } out_item_t;

    // Item function codes.
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // One strobe per controller step.
    typedef struct packed {
        logic idle;
        logic e_wra;
        logic e_wrb;
        logic init;
        logic nextv;
        logic open;
        logic scan;
        logic scan_w;
        logic chk;
        logic retreat;
        logic root_end;
        logic ret_p;
        logic close;
        logic pop_v;
        logic pop_r;
        logic close_end;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic is_end;
        logic i_done;
        logic i_vis;
        logic pos_zero;
        logic w_out;
        logic w_new;
        logic root_end;
        logic has_nb;
        logic low_less;
        logic close_now;
        logic sp_zero;
        logic pop_hit;
        logic pend_wait;
        logic ret_scan;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/bbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bbc_ctrl.sv
// Sequencer for the biconnected block counter: edge loading steps and the
// depth-first search walk. Depends on bbc_pkg.
`default_nettype none

module bbc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire bbc_pkg::status_t st,
    output bbc_pkg::cmd_t        cmd
);
    import bbc_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_E_WRA     = 18'h00002,
        S_E_WRB     = 18'h00004,
        S_INIT      = 18'h00008,
        S_NEXTV     = 18'h00010,
        S_OPEN      = 18'h00020,
        S_SCAN      = 18'h00040,
        S_SCAN_W    = 18'h00080,
        S_CHK       = 18'h00100,
        S_RETREAT   = 18'h00200,
        S_ROOT_END  = 18'h00400,
        S_RET_P     = 18'h00800,
        S_CLOSE     = 18'h01000,
        S_POP_V     = 18'h02000,
        S_POP_R     = 18'h04000,
        S_CLOSE_END = 18'h08000,
        S_EMIT      = 18'h10000,
        S_FINISH    = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && st.is_end)
                    state_next = S_INIT;
                else if (in_valid && st.edge_ok)
                    state_next = S_E_WRA;
            end
            S_E_WRA:     state_next = S_E_WRB;
            S_E_WRB:     state_next = S_IDLE;
            S_INIT:      state_next = S_NEXTV;
            S_NEXTV:
            begin
                if (st.i_done)
                    state_next = S_FINISH;
                else if (!st.i_vis)
                    state_next = S_OPEN;
            end
            S_OPEN:      state_next = S_SCAN;
            S_SCAN:      state_next = st.pos_zero ? S_RETREAT : S_SCAN_W;
            S_SCAN_W:    state_next = st.w_out ? S_SCAN : S_CHK;
            S_CHK:       state_next = st.w_new ? S_OPEN : S_SCAN;
            S_RETREAT:   state_next = st.root_end ? S_ROOT_END : S_RET_P;
            S_ROOT_END:  state_next = st.has_nb ? S_NEXTV : S_EMIT;
            S_RET_P:
            begin
                if (!st.low_less && st.close_now)
                    state_next = S_CLOSE;
                else
                    state_next = S_SCAN;
            end
            S_CLOSE:     state_next = st.sp_zero ? S_CLOSE_END : S_POP_V;
            S_POP_V:     state_next = S_POP_R;
            S_POP_R:     state_next = st.pop_hit ? S_CLOSE_END : S_CLOSE;
            S_CLOSE_END: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!st.pend_wait)
                    state_next = st.ret_scan ? S_SCAN : S_NEXTV;
            end
            S_FINISH:
            begin
                if (!st.pend_wait)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.idle      = (state_reg == S_IDLE);
    assign cmd.e_wra     = (state_reg == S_E_WRA);
    assign cmd.e_wrb     = (state_reg == S_E_WRB);
    assign cmd.init      = (state_reg == S_INIT);
    assign cmd.nextv     = (state_reg == S_NEXTV);
    assign cmd.open      = (state_reg == S_OPEN);
    assign cmd.scan      = (state_reg == S_SCAN);
    assign cmd.scan_w    = (state_reg == S_SCAN_W);
    assign cmd.chk       = (state_reg == S_CHK);
    assign cmd.retreat   = (state_reg == S_RETREAT);
    assign cmd.root_end  = (state_reg == S_ROOT_END);
    assign cmd.ret_p     = (state_reg == S_RET_P);
    assign cmd.close     = (state_reg == S_CLOSE);
    assign cmd.pop_v     = (state_reg == S_POP_V);
    assign cmd.pop_r     = (state_reg == S_POP_R);
    assign cmd.close_end = (state_reg == S_CLOSE_END);
    assign cmd.emit      = (state_reg == S_EMIT);
    assign cmd.finish    = (state_reg == S_FINISH);

endmodule

`default_nettype wire

FILE: rtl/core/bbc_datapath.sv
// Datapath of the biconnected block counter: adjacency memories, vertex
// records, block stack, result buffering. Depends on bbc_pkg and bbc_ram.
`default_nettype none

module bbc_datapath #(
    parameter int MAX_VERTICES = bbc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bbc_pkg::DEF_MAX_EDGES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire bbc_pkg::in_item_t  in_item,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output bbc_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    input  wire logic [6:0]         cfg_data,
    input  wire bbc_pkg::cmd_t      cmd,
    output bbc_pkg::status_t        st
);
    import bbc_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int PW     = VW + 1;
    localparam int LW     = $clog2(2 * MAX_EDGES + 1);
    localparam int FW     = $clog2(MAX_EDGES + 1);
    localparam int SAW    = $clog2(2 * MAX_EDGES);
    localparam int SD     = 2 * MAX_VERTICES;
    localparam int SPW    = $clog2(SD + 1);
    localparam int STW    = $clog2(SD);
    localparam int EW_RAW = $clog2(2 * MAX_EDGES + MAX_VERTICES + 1);
    localparam int EW     = (EW_RAW > 10) ? EW_RAW : 10;
    localparam int RW     = 1 + PW + 2 * VW + 2 * LW;
    localparam int NW     = VW + LW;
    localparam int O_RET  = LW;
    localparam int O_LOW  = 2 * LW;
    localparam int O_LVL  = 2 * LW + VW;
    localparam int O_PAR  = 2 * LW + 2 * VW;
    localparam int O_OPEN = RW - 1;

    logic [6:0]        vcount_reg;
    logic [FW-1:0]     fill_reg;
    logic              dropped_reg;
    logic [MAX_VERTICES-1:0] hv_reg;
    logic [MAX_VERTICES-1:0] vis_reg;
    logic [VW-1:0]     ea_reg;
    logic [VW-1:0]     eb_reg;
    logic [6:0]        i_reg;
    logic [VW-1:0]     cur_reg;
    logic              cur_open_reg;
    logic [PW-1:0]     cur_par_reg;
    logic [VW-1:0]     cur_lvl_reg;
    logic [VW-1:0]     cur_low_reg;
    logic [LW-1:0]     cur_ret_reg;
    logic [LW-1:0]     cur_pos_reg;
    logic [VW-1:0]     w_reg;
    logic              has_nb_reg;
    logic [SPW-1:0]    sp_reg;
    logic [VW-1:0]     cut_reg;
    logic [6:0]        verts_reg;
    logic [EW-1:0]     edges_reg;
    logic [6:0]        res_v_reg;
    logic [8:0]        res_e_reg;
    logic              ret_scan_reg;
    logic              pend_valid_reg;
    out_item_t         pend_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [6:0]        n_cnt;
    logic [6:0]        a_m1;
    logic [6:0]        b_m1;
    logic              fire;
    logic [LW-1:0]     link_a;
    logic [LW-1:0]     link_b;
    logic [FW:0]       slot_w;
    logic [LW-1:0]     pos_m1;
    logic [SPW-1:0]    sp_m1;
    logic              sp_nz;
    logic              out_free;
    logic              push;
    logic              stack_we;

    logic              head_we;
    logic [VW-1:0]     head_waddr;
    logic [LW-1:0]     head_wdata;
    logic [VW-1:0]     head_raddr;
    logic [LW-1:0]     head_rdata;
    logic [LW-1:0]     head_a;
    logic [LW-1:0]     head_b;

    logic              nbr_we;
    logic [NW-1:0]     nbr_wdata;
    logic [NW-1:0]     nbr_rdata;
    logic [VW-1:0]     sv;
    logic [LW-1:0]     snext;

    logic              rec_we;
    logic [RW-1:0]     rec_wdata;
    logic [VW-1:0]     rec_raddr;
    logic [RW-1:0]     rd;
    logic [LW-1:0]     rd_pos;
    logic [LW-1:0]     rd_ret;
    logic [VW-1:0]     rd_low;
    logic [VW-1:0]     rd_lvl;
    logic [PW-1:0]     rd_par;
    logic              rd_open;

    logic [VW-1:0]     stk_rdata;

    logic              w_self;
    logic              rw_vis;
    logic              rw_open;
    logic [VW-1:0]     rw_lvl;
    logic              w_back;

    assign n_cnt  = (vcount_reg > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_reg;
    assign a_m1   = in_item.first_vertex - 7'd1;
    assign b_m1   = in_item.second_vertex - 7'd1;
    assign fire   = cmd.idle && in_valid;
    assign link_a = LW'({fill_reg, 1'b1});
    assign link_b = link_a + LW'(1);
    assign slot_w = {fill_reg, cmd.e_wrb};
    assign pos_m1 = cur_pos_reg - LW'(1);
    assign sp_m1  = sp_reg - SPW'(1);
    assign sp_nz  = (sp_reg != '0);

    // Adjacency list heads; an entry without its valid bit is a null link.
    assign head_a = hv_reg[ea_reg] ? head_rdata : '0;
    assign head_b = (ea_reg == eb_reg) ? link_a : (hv_reg[eb_reg] ? head_rdata : '0);

    assign head_we    = cmd.e_wra || cmd.e_wrb;
    assign head_waddr = cmd.e_wra ? ea_reg : eb_reg;
    assign head_wdata = cmd.e_wra ? link_a : link_b;

    always_comb
    begin
        head_raddr = cur_reg;
        if (cmd.idle)
            head_raddr = a_m1[VW-1:0];
        else if (cmd.e_wra)
            head_raddr = eb_reg;
        else if (cmd.nextv)
            head_raddr = i_reg[VW-1:0];
        else if (cmd.chk)
            head_raddr = w_reg;
    end

    bbc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    assign nbr_we    = cmd.e_wra || cmd.e_wrb;
    assign nbr_wdata = cmd.e_wra ? {eb_reg, head_a} : {ea_reg, head_b};

    bbc_ram #(.WIDTH(NW), .DEPTH(2 * MAX_EDGES)) u_nbrs (
        .clk   (clk),
        .we    (nbr_we),
        .waddr (slot_w[SAW-1:0]),
        .wdata (nbr_wdata),
        .raddr (pos_m1[SAW-1:0]),
        .rdata (nbr_rdata)
    );

    assign sv    = nbr_rdata[NW-1:LW];
    assign snext = nbr_rdata[LW-1:0];

    // The record of the current vertex lives in registers; memory holds the rest.
    assign w_self  = (w_reg == cur_reg);
    assign rw_vis  = w_self || vis_reg[w_reg];
    assign rw_open = w_self ? cur_open_reg : rd_open;
    assign rw_lvl  = w_self ? cur_lvl_reg : rd_lvl;
    assign w_back  = rw_vis && rw_open && ({1'b0, w_reg} != cur_par_reg);

    assign rec_we    = (cmd.chk && !rw_vis) || cmd.retreat;
    assign rec_wdata = {cur_open_reg && !cmd.retreat, cur_par_reg, cur_lvl_reg,
                        cur_low_reg, cur_ret_reg, cur_pos_reg};

    always_comb
    begin
        rec_raddr = w_reg;
        if (cmd.scan_w)
            rec_raddr = sv;
        else if (cmd.retreat)
            rec_raddr = cur_par_reg[VW-1:0];
        else if (cmd.pop_v)
            rec_raddr = stk_rdata;
    end

    bbc_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_recs (
        .clk   (clk),
        .we    (rec_we),
        .waddr (cur_reg),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rd)
    );

    assign rd_pos  = rd[O_RET-1:0];
    assign rd_ret  = rd[O_LOW-1:O_RET];
    assign rd_low  = rd[O_LVL-1:O_LOW];
    assign rd_lvl  = rd[O_PAR-1:O_LVL];
    assign rd_par  = rd[O_OPEN-1:O_PAR];
    assign rd_open = rd[O_OPEN];

    assign stack_we = ((cmd.nextv && !st.i_done && !st.i_vis) || (cmd.chk && !rw_vis))
                      && (sp_reg < SPW'(SD));

    bbc_ram #(.WIDTH(VW), .DEPTH(SD)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (sp_reg[STW-1:0]),
        .wdata (cmd.nextv ? i_reg[VW-1:0] : w_reg),
        .raddr (sp_m1[STW-1:0]),
        .rdata (stk_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign push     = (cmd.emit || cmd.finish) && pend_valid_reg && out_free;

    assign st.edge_ok   = (in_item.first_vertex != 7'd0) && (in_item.second_vertex != 7'd0)
                          && (in_item.first_vertex <= n_cnt)
                          && (in_item.second_vertex <= n_cnt)
                          && (fill_reg < FW'(MAX_EDGES));
    assign st.is_end    = (in_item.func == FUNC_END);
    assign st.i_done    = (i_reg >= n_cnt);
    assign st.i_vis     = vis_reg[i_reg[VW-1:0]];
    assign st.pos_zero  = (cur_pos_reg == '0);
    assign st.w_out     = (7'(sv) >= n_cnt);
    assign st.w_new     = !rw_vis;
    assign st.root_end  = (cur_reg == i_reg[VW-1:0]) || cur_par_reg[PW-1];
    assign st.has_nb    = has_nb_reg;
    assign st.low_less  = (cur_low_reg < rd_low);
    assign st.close_now = rd_par[PW-1] || (rd_lvl <= cur_low_reg);
    assign st.sp_zero   = !sp_nz;
    assign st.pop_hit   = (rd_par == {1'b0, cut_reg});
    assign st.pend_wait = pend_valid_reg && !out_free;
    assign st.ret_scan  = ret_scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= 7'd1;
            fill_reg       <= '0;
            dropped_reg    <= 1'b0;
            hv_reg         <= '0;
            vis_reg        <= '0;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                vcount_reg <= cfg_data;
            if (fire && (in_item.func == FUNC_EDGE) && !st.edge_ok)
                dropped_reg <= 1'b1;
            if (cmd.e_wra)
                hv_reg[ea_reg] <= 1'b1;
            if (cmd.e_wrb)
            begin
                hv_reg[eb_reg] <= 1'b1;
                fill_reg       <= fill_reg + FW'(1);
            end
            if (cmd.init)
            begin
                vis_reg        <= '0;
                sp_reg         <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.nextv && !st.i_done && !st.i_vis)
                vis_reg[i_reg[VW-1:0]] <= 1'b1;
            if (cmd.chk && !rw_vis)
                vis_reg[w_reg] <= 1'b1;
            if (stack_we)
                sp_reg <= sp_reg + SPW'(1);
            if (cmd.close && sp_nz)
                sp_reg <= sp_m1;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (push)
                out_valid_reg <= 1'b1;
            if (cmd.emit && !st.pend_wait)
                pend_valid_reg <= 1'b1;
            if (cmd.finish && !st.pend_wait)
            begin
                pend_valid_reg <= 1'b0;
                hv_reg         <= '0;
                fill_reg       <= '0;
                dropped_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ea_reg <= a_m1[VW-1:0];
            eb_reg <= b_m1[VW-1:0];
        end
        if (cmd.init)
            i_reg <= 7'd0;
        if (cmd.nextv && !st.i_done)
        begin
            if (st.i_vis)
            begin
                i_reg <= i_reg + 7'd1;
            end
            else
            begin
                cur_reg      <= i_reg[VW-1:0];
                cur_open_reg <= 1'b1;
                cur_par_reg  <= {1'b1, {VW{1'b0}}};
                cur_lvl_reg  <= '0;
                cur_low_reg  <= '0;
                cur_ret_reg  <= '0;
                has_nb_reg   <= 1'b0;
            end
        end
        if (cmd.open)
            cur_pos_reg <= hv_reg[cur_reg] ? head_rdata : '0;
        if (cmd.scan_w)
        begin
            w_reg       <= sv;
            cur_pos_reg <= snext;
            if (!st.w_out && (cur_reg == i_reg[VW-1:0]))
                has_nb_reg <= 1'b1;
        end
        if (cmd.chk)
        begin
            if (!rw_vis)
            begin
                cur_reg      <= w_reg;
                cur_open_reg <= 1'b1;
                cur_par_reg  <= {1'b0, cur_reg};
                cur_lvl_reg  <= cur_lvl_reg + VW'(1);
                cur_low_reg  <= cur_lvl_reg + VW'(1);
                cur_ret_reg  <= '0;
            end
            else if (w_back)
            begin
                if (rw_lvl < cur_low_reg)
                    cur_low_reg <= rw_lvl;
                cur_ret_reg <= cur_ret_reg + LW'(1);
            end
        end
        if (cmd.root_end)
        begin
            i_reg        <= i_reg + 7'd1;
            res_v_reg    <= 7'd1;
            res_e_reg    <= 9'd0;
            ret_scan_reg <= 1'b0;
        end
        // Step back to the parent and fold the child's lowpoint into it.
        if (cmd.ret_p)
        begin
            cur_reg      <= cur_par_reg[VW-1:0];
            cut_reg      <= cur_par_reg[VW-1:0];
            cur_open_reg <= rd_open;
            cur_par_reg  <= rd_par;
            cur_lvl_reg  <= rd_lvl;
            cur_low_reg  <= st.low_less ? cur_low_reg : rd_low;
            cur_ret_reg  <= rd_ret;
            cur_pos_reg  <= rd_pos;
            verts_reg    <= 7'd0;
            edges_reg    <= '0;
        end
        if (cmd.pop_r)
        begin
            verts_reg <= verts_reg + 7'd1;
            edges_reg <= edges_reg + EW'(rd_ret) + EW'(1);
        end
        if (cmd.close_end)
        begin
            res_v_reg    <= verts_reg + {6'd0, sp_nz};
            res_e_reg    <= (edges_reg > EW'(511)) ? 9'd511 : edges_reg[8:0];
            ret_scan_reg <= 1'b1;
        end
        if (cmd.emit && !st.pend_wait)
        begin
            pend_reg.block_vertices <= res_v_reg;
            pend_reg.block_edges    <= res_e_reg;
            pend_reg.last_block     <= 1'b0;
            pend_reg.input_dropped  <= dropped_reg;
        end
        if (push)
        begin
            out_reg            <= pend_reg;
            out_reg.last_block <= cmd.finish;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(SD))
        else $error("block stack pointer beyond stack depth");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_EDGES))
        else $error("edge fill beyond capacity");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> (vis_reg == '0) && (sp_reg == '0) && !pend_valid_reg)
        else $error("search stores not cleared at start");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !st.pend_wait) |=> (hv_reg == '0) && (fill_reg == '0) && !dropped_reg)
        else $error("loaded graph not cleared after the search");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/biconnected_block_counter_top.sv
// Top level of the biconnected block counter: joins the sequencer and the
// datapath. Depends on bbc_pkg, bbc_ctrl, bbc_datapath, bbc_ram.
`default_nettype none

// Edge items (func 0) are stored into the adjacency lists: the accepting step
// reads the first list head, and the write steps store both neighbor entries
// via the single write port of the neighbor and head memories. A dropped
// edge passes only the accepting step. The end item (func 1) runs a lowpoint
// depth-first search and stalls the input until the last block result is
// handed over. The search time is set by the registered single read port of
// the vertex record memory: a neighbor entry passes scan, read and check (no
// check when the neighbor is at or above the vertex count), an opened vertex
// open, retreat and return or root end, a popped vertex close, pop-vertex and
// pop-record, plus waiting on a stalled output. Result items come one per
// biconnected block, in the order found, and the final one carries
// last_block. No clearing pass is needed after reset.
module biconnected_block_counter_top #(
    parameter int MAX_VERTICES = bbc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bbc_pkg::DEF_MAX_EDGES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire bbc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output bbc_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [6:0]         cfg_data
);
    import bbc_pkg::*;

    cmd_t    cmd;
    status_t st;

    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd)
    );

    bbc_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

    assign in_stall  = !cmd.idle;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for biconnected_block_counter_top: loads random and hand-built graphs,
// runs the block search and checks every block result against a built-in predictor.
// Depends on bbc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import bbc_pkg::*;

    localparam int NVERT = 64;
    localparam int NSLOT = 512;
    localparam int NO_PAR = 255;
    localparam int TARGET_ITEMS = 410;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [6:0] cfg_data = '0;

    // Predictor state: loaded graph, search records and the count register.
    int vcount;
    int nb_vertex[NSLOT];
    int nb_next[NSLOT];
    int heads[NVERT];
    int vstate[NVERT];
    int vparent[NVERT];
    int vlevel[NVERT];
    int vlow[NVERT];
    int vret[NVERT];
    int vpos[NVERT];
    int vstack[2 * NVERT];
    int sp;
    int edge_fill;
    bit dropped;
    out_item_t found_blocks[$];
    out_item_t pending_blocks[$];

    int errors = 0;
    int items_sent = 0;
    bit quiet = 1'b0;

    biconnected_block_counter_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int active_n();
        return vcount > NVERT ? NVERT : vcount;
    endfunction

    function automatic void load_edge(int a, int b);
        int n;
        int slot;
        n = active_n();
        if (a == 0 || b == 0 || a > n || b > n || edge_fill >= 256)
        begin
            dropped = 1'b1;
            return;
        end
        slot = 2 * edge_fill;
        nb_vertex[slot] = b - 1;
        nb_next[slot] = heads[a - 1];
        heads[a - 1] = slot + 1;
        nb_vertex[slot + 1] = a - 1;
        nb_next[slot + 1] = heads[b - 1];
        heads[b - 1] = slot + 2;
        edge_fill++;
    endfunction

    function automatic void emit_block(int verts, int edges);
        out_item_t r;
        if (found_blocks.size() >= 64)
            return;
        r.block_vertices = verts[6:0];
        r.block_edges = (edges > 511) ? 9'd511 : edges[8:0];
        r.last_block = 1'b0;
        r.input_dropped = dropped;
        found_blocks.push_back(r);
    endfunction

    function automatic void close_block(int cut);
        int verts;
        int edges;
        int v;
        verts = 0;
        edges = 0;
        while (sp > 0)
        begin
            sp--;
            v = vstack[sp] % NVERT;
            verts++;
            edges += vret[v] + 1;
            if (vparent[v] == cut)
                break;
        end
        if (sp > 0)
            verts++;
        emit_block(verts, edges);
    endfunction

    function automatic void open_vertex(int v);
        vstate[v] = 1;
        vpos[v] = heads[v];
        if (sp < 2 * NVERT)
        begin
            vstack[sp] = v;
            sp++;
        end
    endfunction

    // Lowpoint search over the loaded graph; queues one result per block.
    function automatic void predict_blocks();
        int n;
        int cur;
        int slot;
        int w;
        int p;
        bit has_nb;
        n = active_n();
        found_blocks.delete();
        for (int k = 0; k < NVERT; k++)
        begin
            vstate[k] = 0;
            vparent[k] = NO_PAR;
            vlevel[k] = 0;
            vlow[k] = 0;
            vret[k] = 0;
            vpos[k] = 0;
        end
        sp = 0;
        for (int i = 0; i < n; i++)
        begin
            if (vstate[i] != 0)
                continue;
            has_nb = 1'b0;
            open_vertex(i);
            cur = i;
            forever
            begin
                if (vpos[cur] != 0 && vpos[cur] <= NSLOT)
                begin
                    slot = vpos[cur] - 1;
                    w = nb_vertex[slot];
                    vpos[cur] = nb_next[slot];
                    if (w >= n)
                        continue;
                    if (cur == i)
                        has_nb = 1'b1;
                    if (vstate[w] == 1 && w != vparent[cur])
                    begin
                        if (vlevel[w] < vlow[cur])
                            vlow[cur] = vlevel[w];
                        vret[cur]++;
                    end
                    else if (vstate[w] == 0)
                    begin
                        vparent[w] = cur;
                        vlevel[w] = vlevel[cur] + 1;
                        vlow[w] = vlevel[w];
                        open_vertex(w);
                        cur = w;
                    end
                end
                else
                begin
                    vstate[cur] = 2;
                    if (cur == i || vparent[cur] == NO_PAR)
                        break;
                    p = vparent[cur] % NVERT;
                    if (vlow[cur] < vlow[p])
                        vlow[p] = vlow[cur];
                    else if (vparent[p] == NO_PAR || vlevel[p] <= vlow[cur])
                        close_block(p);
                    cur = p;
                end
            end
            if (!has_nb)
                emit_block(1, 0);
        end
        if (found_blocks.size() > 0)
            found_blocks[found_blocks.size() - 1].last_block = 1'b1;
        foreach (found_blocks[k])
            pending_blocks.push_back(found_blocks[k]);
        for (int k = 0; k < NVERT; k++)
            heads[k] = 0;
        edge_fill = 0;
        dropped = 1'b0;
    endfunction

    // Sends one item; valid stays high afterward so items can go back to back.
    task automatic send_item(logic func, int a, int b);
        if (!quiet && $urandom_range(99) < 21)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item.func = func;
        in_item.first_vertex = a[6:0];
        in_item.second_vertex = b[6:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (func == FUNC_EDGE)
            load_edge(a, b);
        else
            predict_blocks();
        items_sent++;
        @(negedge clk);
    endtask

    // Lets the block finish all work before a register write.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_blocks.size() > 0 || in_stall)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(int v);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data = v[6:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vcount = v & 8'h7f;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_directed();
        // Triangle with a bridge to a leaf, a self loop, a repeated edge, bad vertices.
        write_count(5);
        send_item(FUNC_EDGE, 1, 2);
        send_item(FUNC_EDGE, 2, 3);
        send_item(FUNC_EDGE, 3, 1);
        send_item(FUNC_EDGE, 3, 4);
        send_item(FUNC_EDGE, 4, 4);
        send_item(FUNC_EDGE, 1, 2);
        send_item(FUNC_EDGE, 0, 2);
        send_item(FUNC_EDGE, 6, 1);
        send_item(FUNC_EDGE, 127, 127);
        send_item(FUNC_END, 127, 127);
        // A lone self loop on the only vertex.
        write_count(1);
        send_item(FUNC_EDGE, 1, 1);
        send_item(FUNC_END, 0, 0);
        // Empty graph gives no result.
        write_count(0);
        send_item(FUNC_EDGE, 1, 1);
        send_item(FUNC_END, 0, 0);
        // Edges loaded at full count, then the count shrinks before the search.
        write_count(64);
        send_item(FUNC_EDGE, 64, 1);
        send_item(FUNC_EDGE, 1, 2);
        send_item(FUNC_EDGE, 2, 3);
        send_item(FUNC_EDGE, 3, 64);
        write_count(3);
        send_item(FUNC_END, 1, 1);
        write_count(127);
        send_item(FUNC_EDGE, 64, 63);
        send_item(FUNC_END, 0, 0);
    endtask

    task automatic test_capacity();
        write_count(64);
        for (int k = 0; k < 260; k++)
            send_item(FUNC_EDGE, $urandom_range(64, 1), $urandom_range(64, 1));
        send_item(FUNC_END, 0, 0);
    endtask

    task automatic test_random();
        int n;
        int edges;
        int graphs;
        int a;
        int b;
        graphs = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            quiet = (graphs >= 6 && graphs < 12);
            case ($urandom_range(9))
                0: n = 64;
                1: n = 1;
                2: n = $urandom_range(127, 65);
                default: n = $urandom_range(12, 1);
            endcase
            write_count(n);
            edges = $urandom_range(2 * (n > 12 ? 12 : n));
            for (int k = 0; k < edges; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    a = $urandom_range(127);
                    b = $urandom_range(127);
                end
                else
                begin
                    a = $urandom_range(n > 64 ? 64 : n, 1);
                    b = $urandom_range(n > 64 ? 64 : n, 1);
                end
                send_item(FUNC_EDGE, a, b);
            end
            send_item(FUNC_END, $urandom_range(127), $urandom_range(127));
            graphs++;
        end
        quiet = 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 21);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_item);
                errors++;
            end
            else
            begin
                if (out_item !== pending_blocks[0])
                begin
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, pending_blocks[0], out_item);
                    errors++;
                end
                void'(pending_blocks.pop_front());
            end
        end
    end

    initial
    begin
        vcount = 1;
        sp = 0;
        edge_fill = 0;
        dropped = 1'b0;
        for (int k = 0; k < NVERT; k++)
            heads[k] = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_capacity();
        test_random();
        in_valid = 1'b0;
        while (pending_blocks.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_datapath.sv
rtl/core/biconnected_block_counter_top.sv
sim/testbench.sv
